// ===== design/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types, constants and character tables of the pronounceable id codec.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int WordW   = 48;
  localparam int CharW   = 8;
  localparam int TextLen = 21;
  localparam int PosW    = $clog2(TextLen + 1);
  localparam int IdxW    = $clog2(TextLen);
  localparam int SumW    = 16;

  localparam logic [CharW-1:0] DashChar  = 8'h2d;
  localparam logic [CharW-1:0] ZeroChar  = 8'h30;
  localparam logic [CharW-1:0] UpperA    = 8'h41;
  localparam logic [CharW-1:0] UpperZ    = 8'h5a;
  localparam logic [CharW-1:0] CaseBit   = 8'h20;

  localparam logic [PosW-1:0] LastLetterPos = PosW'(16);
  localparam logic [PosW-1:0] FirstDigitPos = PosW'(18);
  localparam logic [PosW-1:0] MidDigitPos   = PosW'(19);
  localparam logic [PosW-1:0] LastDigitPos  = PosW'(20);
  localparam logic [PosW-1:0] EndPos        = PosW'(TextLen);
  localparam logic [IdxW-1:0] LastIdx       = IdxW'(TextLen - 1);

  // checksum digits that never arrived count as code 0, i.e. -48 times weight
  localparam logic [SumW-1:0] FillThree = SumW'(-5328);
  localparam logic [SumW-1:0] FillTwo   = SumW'(-528);
  localparam logic [SumW-1:0] FillOne   = SumW'(-48);

  typedef enum logic [2:0] {
    SLOT_CONS,
    SLOT_VOWEL,
    SLOT_DASH,
    SLOT_DIGIT,
    SLOT_NONE
  } slot_kind_t;

  typedef struct packed {
    slot_kind_t  kind;
    logic [5:0]  shift;
    logic [6:0]  weight;
  } slot_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] code;
  } letter_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             ok;
  } dec_result_t;

  // what each text position holds, and where its bits sit in the word
  function automatic slot_t slot_info(input logic [PosW-1:0] pos);
    slot_t s;
    s.kind   = SLOT_NONE;
    s.shift  = 6'd0;
    s.weight = 7'd0;
    case (pos)
      5'd0:  begin s.kind = SLOT_CONS;  s.shift = 6'd0;  end
      5'd1:  begin s.kind = SLOT_VOWEL; s.shift = 6'd4;  end
      5'd2:  begin s.kind = SLOT_CONS;  s.shift = 6'd6;  end
      5'd3:  begin s.kind = SLOT_VOWEL; s.shift = 6'd10; end
      5'd4:  begin s.kind = SLOT_CONS;  s.shift = 6'd12; end
      5'd5:  begin s.kind = SLOT_DASH;  end
      5'd6:  begin s.kind = SLOT_CONS;  s.shift = 6'd16; end
      5'd7:  begin s.kind = SLOT_VOWEL; s.shift = 6'd20; end
      5'd8:  begin s.kind = SLOT_CONS;  s.shift = 6'd22; end
      5'd9:  begin s.kind = SLOT_VOWEL; s.shift = 6'd26; end
      5'd10: begin s.kind = SLOT_CONS;  s.shift = 6'd28; end
      5'd11: begin s.kind = SLOT_DASH;  end
      5'd12: begin s.kind = SLOT_CONS;  s.shift = 6'd32; end
      5'd13: begin s.kind = SLOT_VOWEL; s.shift = 6'd36; end
      5'd14: begin s.kind = SLOT_CONS;  s.shift = 6'd38; end
      5'd15: begin s.kind = SLOT_VOWEL; s.shift = 6'd42; end
      5'd16: begin s.kind = SLOT_CONS;  s.shift = 6'd44; end
      5'd17: begin s.kind = SLOT_DASH;  end
      5'd18: begin s.kind = SLOT_DIGIT; s.weight = 7'd100; end
      5'd19: begin s.kind = SLOT_DIGIT; s.weight = 7'd10;  end
      5'd20: begin s.kind = SLOT_DIGIT; s.weight = 7'd1;   end
      default: begin s.kind = SLOT_NONE; end
    endcase
    return s;
  endfunction

  // consonant letters b d f g h j k l m n p r s t v z
  function automatic logic [CharW-1:0] cons_char(input logic [3:0] code);
    logic [CharW-1:0] c;
    case (code)
      4'd0:  c = 8'h62;
      4'd1:  c = 8'h64;
      4'd2:  c = 8'h66;
      4'd3:  c = 8'h67;
      4'd4:  c = 8'h68;
      4'd5:  c = 8'h6a;
      4'd6:  c = 8'h6b;
      4'd7:  c = 8'h6c;
      4'd8:  c = 8'h6d;
      4'd9:  c = 8'h6e;
      4'd10: c = 8'h70;
      4'd11: c = 8'h72;
      4'd12: c = 8'h73;
      4'd13: c = 8'h74;
      4'd14: c = 8'h76;
      default: c = 8'h7a;
    endcase
    return c;
  endfunction

  // vowel letters a i o u
  function automatic logic [CharW-1:0] vowel_char(input logic [1:0] code);
    logic [CharW-1:0] c;
    case (code)
      2'd0:    c = 8'h61;
      2'd1:    c = 8'h69;
      2'd2:    c = 8'h6f;
      default: c = 8'h75;
    endcase
    return c;
  endfunction

  function automatic letter_t cons_code(input logic [CharW-1:0] c);
    letter_t l;
    l.ok = 1'b1;
    case (c)
      8'h62: l.code = 4'd0;
      8'h64: l.code = 4'd1;
      8'h66: l.code = 4'd2;
      8'h67: l.code = 4'd3;
      8'h68: l.code = 4'd4;
      8'h6a: l.code = 4'd5;
      8'h6b: l.code = 4'd6;
      8'h6c: l.code = 4'd7;
      8'h6d: l.code = 4'd8;
      8'h6e: l.code = 4'd9;
      8'h70: l.code = 4'd10;
      8'h72: l.code = 4'd11;
      8'h73: l.code = 4'd12;
      8'h74: l.code = 4'd13;
      8'h76: l.code = 4'd14;
      8'h7a: l.code = 4'd15;
      default: begin
        l.ok   = 1'b0;
        l.code = 4'd0;
      end
    endcase
    return l;
  endfunction

  function automatic letter_t vowel_code(input logic [CharW-1:0] c);
    letter_t l;
    l.ok = 1'b1;
    case (c)
      8'h61: l.code = 4'd0;
      8'h69: l.code = 4'd1;
      8'h6f: l.code = 4'd2;
      8'h75: l.code = 4'd3;
      default: begin
        l.ok   = 1'b0;
        l.code = 4'd0;
      end
    endcase
    return l;
  endfunction

  // negated 8-bit sum of the six bytes
  function automatic logic [7:0] checksum8(input logic [WordW-1:0] w);
    logic [10:0] s;
    s = 11'd0;
    for (int i = 0; i < WordW / 8; i++) begin
      s = s + {3'b000, w[8*i +: 8]};
    end
    return 8'(~s + 11'd1);
  endfunction

  // digit correction for checksum positions from pos to the end
  function automatic logic [SumW-1:0] digit_fill(input logic [PosW-1:0] pos);
    logic [SumW-1:0] f;
    if (pos <= FirstDigitPos) begin
      f = FillThree;
    end else if (pos == MidDigitPos) begin
      f = FillTwo;
    end else if (pos == LastDigitPos) begin
      f = FillOne;
    end else begin
      f = '0;
    end
    return f;
  endfunction

endpackage

// ===== design/pic_encoder.sv =====
// ----------------------------------------------------------------------------
// pic_encoder
// Builds the 21-character text of a word: three letter groups and checksum.
// ----------------------------------------------------------------------------
module pic_encoder (
  input  logic [pic_pkg::WordW-1:0]                        word,
  output logic [pic_pkg::TextLen-1:0][pic_pkg::CharW-1:0]  text
);

  logic [7:0]  ck;
  logic [1:0]  hund;
  logic [7:0]  rem8;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  ones;

  // checksum split into decimal digits without a divider
  always_comb begin
    ck        = pic_pkg::checksum8(word);
    hund      = (ck >= 8'd200) ? 2'd2 : ((ck >= 8'd100) ? 2'd1 : 2'd0);
    rem8      = ck - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
    rem       = rem8[6:0];
    tens_prod = {8'b0, rem} * 15'd205;
    tens      = tens_prod[14:11];
    ones      = 4'(rem - 7'(tens) * 7'd10);
  end

  // letter and dash positions from the word fields, then the checksum digits
  always_comb begin
    pic_pkg::slot_t s;
    logic [pic_pkg::WordW-1:0] f;
    for (int i = 0; i < pic_pkg::TextLen; i++) begin
      s = pic_pkg::slot_info(pic_pkg::PosW'(i));
      f = word >> s.shift;
      case (s.kind)
        pic_pkg::SLOT_CONS:  text[i] = pic_pkg::cons_char(f[3:0]);
        pic_pkg::SLOT_VOWEL: text[i] = pic_pkg::vowel_char(f[1:0]);
        pic_pkg::SLOT_DASH:  text[i] = pic_pkg::DashChar;
        default:             text[i] = pic_pkg::ZeroChar;
      endcase
    end
    text[pic_pkg::TextLen-3] = pic_pkg::ZeroChar + {6'b0, hund};
    text[pic_pkg::TextLen-2] = pic_pkg::ZeroChar + {4'b0, tens};
    text[pic_pkg::TextLen-1] = pic_pkg::ZeroChar + {4'b0, ones};
  end

endmodule

// ===== design/pic_decoder.sv =====
// ----------------------------------------------------------------------------
// pic_decoder
// Gathers decoded characters and forms the word and its valid flag.
// ----------------------------------------------------------------------------
module pic_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [pic_pkg::CharW-1:0]  char_in,
  input  logic                       char_is_last,
  output pic_pkg::dec_result_t       result
);

  logic [pic_pkg::PosW-1:0]  pos,  pos_next;
  logic [pic_pkg::WordW-1:0] acc,  acc_next;
  logic                      err,  err_next;
  logic [pic_pkg::SumW-1:0]  dsum, dsum_next;

  pic_pkg::slot_t   slot;
  pic_pkg::letter_t cons_l, vowel_l;
  logic [pic_pkg::CharW-1:0] lc;
  logic [pic_pkg::SumW-1:0]  digit_val;
  logic                      err_final;
  logic [pic_pkg::SumW-1:0]  dsum_final;

  // fold case and look the character up for the current position
  always_comb begin
    slot    = pic_pkg::slot_info(pos);
    lc      = ((char_in >= pic_pkg::UpperA) && (char_in <= pic_pkg::UpperZ)) ?
              (char_in | pic_pkg::CaseBit) : char_in;
    cons_l  = pic_pkg::cons_code(lc);
    vowel_l = pic_pkg::vowel_code(lc);
    digit_val = ({8'b0, char_in} - {8'b0, pic_pkg::ZeroChar}) * {9'b0, slot.weight};
  end

  // state after this character
  always_comb begin
    pos_next  = (pos < pic_pkg::EndPos) ? pos + 1'b1 : pos;
    acc_next  = acc;
    err_next  = err;
    dsum_next = dsum;
    case (slot.kind)
      pic_pkg::SLOT_CONS: begin
        if (cons_l.ok) begin
          acc_next = acc | ({44'b0, cons_l.code} << slot.shift);
        end else begin
          err_next = 1'b1;
        end
      end
      pic_pkg::SLOT_VOWEL: begin
        if (vowel_l.ok) begin
          acc_next = acc | ({44'b0, vowel_l.code} << slot.shift);
        end else begin
          err_next = 1'b1;
        end
      end
      pic_pkg::SLOT_DIGIT: dsum_next = dsum + digit_val;
      default: ;
    endcase
  end

  // close the text: missing letters are illegal, missing digits count as code 0
  always_comb begin
    err_final  = err_next | (pos_next <= pic_pkg::LastLetterPos);
    dsum_final = dsum_next + pic_pkg::digit_fill(pos_next);
    result.ok  = !err_final && (dsum_final == {8'b0, pic_pkg::checksum8(acc_next)});
    result.word = result.ok ? acc_next : '0;
  end

  // decode state, cleared after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      acc  <= '0;
      err  <= 1'b0;
      dsum <= '0;
    end else if (take) begin
      if (char_is_last) begin
        pos  <= '0;
        acc  <= '0;
        err  <= 1'b0;
        dsum <= '0;
      end else begin
        pos  <= pos_next;
        acc  <= acc_next;
        err  <= err_next;
        dsum <= dsum_next;
      end
    end
  end

endmodule

// ===== design/pronounceable_id_codec_core.sv =====
// ----------------------------------------------------------------------------
// pronounceable_id_codec_core
// Proquint-style text codec for a 48-bit word with an 8-bit checksum.
// ----------------------------------------------------------------------------
// The input side takes one item per cycle while s_tready is high. An encode
// item (tuser = 0) turns the word in tdata into 21 output items, three
// five-letter groups with dashes and three checksum digits, the last one
// flagged by tlast; these leave at one item per cycle while m_tready is high,
// and a following encode item or final decode character waits behind them in
// the input register. A decode item (tuser = 1) carries one character; all
// but the character marked tlast are absorbed at once, and only that one
// yields an item, the decoded word and its valid flag. An item passes an
// input register, a run register and the output register, in that order.
module pronounceable_id_codec_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // word_in[47:0], char_in[55:48]
  input  logic        s_tuser,   // mode
  input  logic        s_tlast,   // char_is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // text_char[7:0], word_out[55:8], word_valid[56], zero
  output logic        m_tuser,   // is_decode_result
  output logic        m_tlast    // last_of_run
);

  // input register
  logic                       a_valid;
  logic                       a_mode;
  logic [pic_pkg::WordW-1:0]  a_word;
  logic [pic_pkg::CharW-1:0]  a_char;
  logic                       a_last;
  logic                       a_silent;
  logic                       a_take;

  // run register
  logic                                            b_valid;
  logic                                            b_decode;
  logic [pic_pkg::TextLen-1:0][pic_pkg::CharW-1:0] b_text;
  logic [pic_pkg::IdxW-1:0]                        b_idx;
  logic [pic_pkg::WordW-1:0]                       b_word;
  logic                                            b_ok;
  logic                                            b_load;
  logic                                            b_end;
  logic                                            b_done;

  logic c_load;

  logic [pic_pkg::TextLen-1:0][pic_pkg::CharW-1:0] enc_text;
  pic_pkg::dec_result_t                            dec_res;

  // handshake between the stages
  always_comb begin
    a_silent = a_mode && !a_last;
    c_load   = b_valid && (!m_tvalid || m_tready);
    b_end    = b_decode || (b_idx == pic_pkg::LastIdx);
    b_done   = c_load && b_end;
    a_take   = a_valid && (a_silent || !b_valid || b_done);
    b_load   = a_take && !a_silent;
    s_tready = !a_valid || a_take;
  end

  pic_encoder u_encoder (
    .word (a_word),
    .text (enc_text)
  );

  pic_decoder u_decoder (
    .clk          (clk),
    .rst          (rst),
    .take         (a_take && a_mode),
    .char_in      (a_char),
    .char_is_last (a_last),
    .result       (dec_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_mode <= s_tuser;
      a_word <= s_tdata[47:0];
      a_char <= s_tdata[55:48];
      a_last <= s_tlast;
    end
  end

  // run register: encoded text being drained or one decode result
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_idx   <= '0;
    end else if (b_load) begin
      b_valid <= 1'b1;
      b_idx   <= '0;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end else if (c_load) begin
      b_idx <= b_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_decode <= a_mode;
      b_text   <= enc_text;
      b_word   <= dec_res.word;
      b_ok     <= dec_res.ok;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (c_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      m_tdata[7:0]   <= b_decode ? '0 : b_text[b_idx];
      m_tdata[55:8]  <= b_decode ? b_word : '0;
      m_tdata[56]    <= b_decode && b_ok;
      m_tdata[63:57] <= '0;
      m_tuser        <= b_decode;
      m_tlast        <= b_end;
    end
  end

endmodule

// ===== design/pic_checker.sv =====
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks of the codec, bound to the top level.
// ----------------------------------------------------------------------------
module pic_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [55:0] s_tdata,
  input logic        s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a stalled output item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output item changed while stalled");

  // a decode result is always a run of one item
  a_dec_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("decode result without last flag");

  // encoded characters carry no word and no valid flag
  a_enc_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[63:8] == '0))
    else $error("encoded character with word bits set");

  // an invalid decode result reports a zero word
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser && !m_tdata[56] |-> (m_tdata[55:8] == '0))
    else $error("invalid decode result with nonzero word");

endmodule

bind pronounceable_id_codec_core pic_checker u_pic_checker (.*);
